// File: sv/sbtp_pkg.sv
package sbtp_pkg;

  localparam int KIND_W         = 2;
  localparam int READING_W      = 21;
  localparam int MAG_W          = 20;
  localparam int DIGITS         = 6;
  localparam int DIGIT_W        = 4;
  localparam int BCD_W          = DIGITS * DIGIT_W;
  localparam int STEPS_PER_CELL = 4;
  localparam int N_CELLS        = MAG_W / STEPS_PER_CELL;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 20'd999999;

  localparam logic [KIND_W-1:0] KIND_TEMP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRES = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HUMI = 2'd2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
  localparam logic [DIGIT_W-1:0] DAB_THRESH = 4'd5;
  localparam logic [DIGIT_W-1:0] DAB_ADJ    = 4'd3;

  // Word in flight along the conversion chain.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              negative;
    logic              range_error;
    logic [BCD_W-1:0]  bcd;
    logic [MAG_W-1:0]  bin;
  } work_t;

  // Two decimal digits as a binary value, 0 to 99.
  function automatic logic [6:0] pair_val(logic [DIGIT_W-1:0] hi, logic [DIGIT_W-1:0] lo);
    logic [6:0] acc;
    acc = {3'b000, hi} * 7'd10;
    return acc + {3'b000, lo};
  endfunction

  // Three decimal digits as a binary value, 0 to 999.
  function automatic logic [9:0] triple_val(logic [DIGIT_W-1:0] hi, logic [DIGIT_W-1:0] mid,
                                            logic [DIGIT_W-1:0] lo);
    logic [9:0] acc;
    acc = {6'b000000, hi} * 10'd100;
    acc = acc + {6'b000000, mid} * 10'd10;
    return acc + {6'b000000, lo};
  endfunction

endpackage

// File: sv/sbtp_if.sv
interface sbtp_in_if;
  logic                                valid;
  logic                                ready;
  logic [sbtp_pkg::KIND_W-1:0]         kind;
  logic signed [sbtp_pkg::READING_W-1:0] reading;

  modport source (output valid, kind, reading, input ready);
  modport sink   (input valid, kind, reading, output ready);
endinterface

interface sbtp_out_if;
  logic       valid;
  logic       ready;
  logic       negative;
  logic [3:0] digit_5;
  logic [3:0] digit_4;
  logic [3:0] digit_3;
  logic [3:0] digit_2;
  logic [3:0] digit_1;
  logic [3:0] digit_0;
  logic [7:0] byte_0;
  logic [7:0] byte_1;
  logic [7:0] byte_2;
  logic [7:0] byte_3;
  logic       range_error;

  modport source (output valid, negative, digit_5, digit_4, digit_3, digit_2, digit_1,
                  digit_0, byte_0, byte_1, byte_2, byte_3, range_error, input ready);
  modport sink   (input valid, negative, digit_5, digit_4, digit_3, digit_2, digit_1,
                  digit_0, byte_0, byte_1, byte_2, byte_3, range_error, output ready);
endinterface

// File: sv/sbtp_front.sv
module sbtp_front (
  input  logic                clk,
  input  logic                rst_n,
  sbtp_in_if.sink             in_ch,
  output logic                dn_valid,
  input  logic                dn_ready,
  output sbtp_pkg::work_t     dn_data
);

  logic                                  valid_r;
  sbtp_pkg::work_t                       work_r;
  sbtp_pkg::work_t                       work_nxt;
  logic [sbtp_pkg::READING_W-1:0]        raw;
  logic [sbtp_pkg::READING_W-1:0]        mag_full;
  logic                                  neg;
  logic                                  over;

  assign in_ch.ready = !valid_r || dn_ready;

  // The most negative reading negates to 2^20, which still fits unsigned.
  always_comb begin
    raw      = in_ch.reading;
    neg      = raw[sbtp_pkg::READING_W-1];
    mag_full = neg ? (~raw + 21'd1) : raw;
    over     = mag_full > {1'b0, sbtp_pkg::MAG_LIMIT};

    work_nxt.kind        = in_ch.kind;
    work_nxt.negative    = neg;
    work_nxt.range_error = over;
    work_nxt.bcd         = '0;
    work_nxt.bin         = over ? sbtp_pkg::MAG_LIMIT : mag_full[sbtp_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      work_r <= work_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = work_r;

endmodule

// File: sv/sbtp_dabble_cell.sv
module sbtp_dabble_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  sbtp_pkg::work_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output sbtp_pkg::work_t dn_data
);

  logic            valid_r;
  sbtp_pkg::work_t work_r;
  sbtp_pkg::work_t work_nxt;

  assign up_ready = !valid_r || dn_ready;

  // STEPS_PER_CELL shift-and-add-3 steps; each moves one binary bit into the digits.
  always_comb begin
    work_nxt = up_data;
    for (int s = 0; s < sbtp_pkg::STEPS_PER_CELL; s++) begin
      for (int d = 0; d < sbtp_pkg::DIGITS; d++) begin
        if (work_nxt.bcd[d*sbtp_pkg::DIGIT_W +: sbtp_pkg::DIGIT_W] >= sbtp_pkg::DAB_THRESH) begin
          work_nxt.bcd[d*sbtp_pkg::DIGIT_W +: sbtp_pkg::DIGIT_W] =
            work_nxt.bcd[d*sbtp_pkg::DIGIT_W +: sbtp_pkg::DIGIT_W] + sbtp_pkg::DAB_ADJ;
        end
      end
      {work_nxt.bcd, work_nxt.bin} =
        {work_nxt.bcd[sbtp_pkg::BCD_W-2:0], work_nxt.bin, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      work_r <= work_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = work_r;

endmodule

// File: sv/sbtp_pack.sv
module sbtp_pack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  sbtp_pkg::work_t up_data,
  sbtp_out_if.source      out_ch
);

  logic       valid_r;
  logic       negative_r;
  logic       range_error_r;
  logic [sbtp_pkg::BCD_W-1:0] bcd_r;
  logic [7:0] byte0_r, byte1_r, byte2_r, byte3_r;
  logic [7:0] byte0_nxt, byte1_nxt, byte2_nxt, byte3_nxt;
  logic [3:0] d5, d4, d3, d2, d1, d0;
  logic [6:0] pair_a, pair_b;
  logic [9:0] upper, lower;

  assign up_ready = !valid_r || out_ch.ready;

  always_comb begin
    d5 = up_data.bcd[23:20];
    d4 = up_data.bcd[19:16];
    d3 = up_data.bcd[15:12];
    d2 = up_data.bcd[11:8];
    d1 = up_data.bcd[7:4];
    d0 = up_data.bcd[3:0];
    pair_a = 7'd0;
    pair_b = 7'd0;
    upper  = sbtp_pkg::triple_val(d5, d4, d3);
    lower  = sbtp_pkg::triple_val(d2, d1, d0);
    byte0_nxt = 8'd0;
    byte1_nxt = 8'd0;
    byte2_nxt = 8'd0;
    byte3_nxt = 8'd0;
    case (up_data.kind)
      sbtp_pkg::KIND_TEMP: begin
        pair_a    = sbtp_pkg::pair_val(d3, d2);
        pair_b    = sbtp_pkg::pair_val(d1, d0);
        byte0_nxt = up_data.negative ? (8'd0 - {1'b0, pair_a}) : {1'b0, pair_a};
        byte1_nxt = {1'b0, pair_b};
      end
      sbtp_pkg::KIND_PRES: begin
        byte0_nxt = {6'b000000, upper[9:8]};
        byte1_nxt = upper[7:0];
        byte2_nxt = {6'b000000, lower[9:8]};
        byte3_nxt = lower[7:0];
      end
      sbtp_pkg::KIND_HUMI: begin
        pair_a    = sbtp_pkg::pair_val(d4, d3);
        pair_b    = sbtp_pkg::pair_val(d2, d1);
        byte0_nxt = {1'b0, pair_a};
        byte1_nxt = {1'b0, pair_b};
      end
      default: begin
        byte0_nxt = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      negative_r    <= up_data.negative;
      range_error_r <= up_data.range_error;
      bcd_r         <= up_data.bcd;
      byte0_r       <= byte0_nxt;
      byte1_r       <= byte1_nxt;
      byte2_r       <= byte2_nxt;
      byte3_r       <= byte3_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.negative    = negative_r;
  assign out_ch.range_error = range_error_r;
  assign out_ch.digit_5     = bcd_r[23:20];
  assign out_ch.digit_4     = bcd_r[19:16];
  assign out_ch.digit_3     = bcd_r[15:12];
  assign out_ch.digit_2     = bcd_r[11:8];
  assign out_ch.digit_1     = bcd_r[7:4];
  assign out_ch.digit_0     = bcd_r[3:0];
  assign out_ch.byte_0      = byte0_r;
  assign out_ch.byte_1      = byte1_r;
  assign out_ch.byte_2      = byte2_r;
  assign out_ch.byte_3      = byte3_r;

endmodule

// File: sv/signed_bcd_telemetry_pack_top.sv
// An accepted word passes the sign, cell and pack stage registers in turn to reach out_ch.
// One word per cycle while out_ch is ready; every stage is a register with its own ready.
// The chain is one sign stage, five double-dabble cells of four bits each, one pack stage.
// Reset: synchronous, active low rst_n clears every stage's valid bit; payloads are not reset.
// No clearing pass is needed, so in_ch.ready is high in the first cycle after reset.
module signed_bcd_telemetry_pack_top (
  input  logic        clk,
  input  logic        rst_n,
  sbtp_in_if.sink     in_ch,
  sbtp_out_if.source  out_ch
);

  // Handshake and data along the chain. Position zero is the output of the
  // sign stage; position N_CELLS feeds the packing stage.
  logic [sbtp_pkg::N_CELLS:0] chain_valid;
  logic [sbtp_pkg::N_CELLS:0] chain_ready;
  sbtp_pkg::work_t            chain_data [sbtp_pkg::N_CELLS+1];

  // The sign stage takes the magnitude, saturates it at 999999 and flags the
  // overflow, then loads the binary part of the shift register.
  sbtp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  // Each cell shifts four binary bits into the six BCD digits, correcting
  // any digit of five or more before each shift. After the last cell the
  // binary part is empty and the digits hold the full magnitude.
  for (genvar i = 0; i < sbtp_pkg::N_CELLS; i++) begin : g_cell
    sbtp_dabble_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  // The packing stage forms the telemetry bytes for the selected kind and
  // holds the finished word until the sink takes it.
  sbtp_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_valid[sbtp_pkg::N_CELLS]),
    .up_ready (chain_ready[sbtp_pkg::N_CELLS]),
    .up_data  (chain_data[sbtp_pkg::N_CELLS]),
    .out_ch   (out_ch)
  );

`ifndef ASSERT_OFF
  // Every digit that leaves the chain is a decimal digit.
  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.digit_5 <= sbtp_pkg::DIGIT_MAX) &&
                     (out_ch.digit_4 <= sbtp_pkg::DIGIT_MAX) &&
                     (out_ch.digit_3 <= sbtp_pkg::DIGIT_MAX) &&
                     (out_ch.digit_2 <= sbtp_pkg::DIGIT_MAX) &&
                     (out_ch.digit_1 <= sbtp_pkg::DIGIT_MAX) &&
                     (out_ch.digit_0 <= sbtp_pkg::DIGIT_MAX))
    else $error("digit out of decimal range");

  // A saturated word carries 999999 in its digits.
  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.range_error |->
      (out_ch.digit_5 == sbtp_pkg::DIGIT_MAX) && (out_ch.digit_4 == sbtp_pkg::DIGIT_MAX) &&
      (out_ch.digit_3 == sbtp_pkg::DIGIT_MAX) && (out_ch.digit_2 == sbtp_pkg::DIGIT_MAX) &&
      (out_ch.digit_1 == sbtp_pkg::DIGIT_MAX) && (out_ch.digit_0 == sbtp_pkg::DIGIT_MAX))
    else $error("range error without saturated digits");

  // Zero is never reported as negative.
  a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.negative |->
      (out_ch.digit_5 != 4'd0) || (out_ch.digit_4 != 4'd0) || (out_ch.digit_3 != 4'd0) ||
      (out_ch.digit_2 != 4'd0) || (out_ch.digit_1 != 4'd0) || (out_ch.digit_0 != 4'd0))
    else $error("negative word with zero magnitude");
`endif

endmodule

// File: test/tb_signed_bcd_telemetry_pack_top.sv
`timescale 1ns / 1ps

module tb_signed_bcd_telemetry_pack_top;

  typedef logic        [sbtp_pkg::KIND_W-1:0]    kind_t;
  typedef logic signed [sbtp_pkg::READING_W-1:0] reading_t;

  // Kind code 3 has no packing format; the block must still convert the digits
  // and leave all four packed bytes at zero.
  localparam kind_t KIND_UNUSED = 2'd3;

  // Cycles with no word moving on either channel before the run is declared hung.
  // The longest sender gap and a full receiver stall pattern are both far shorter than
  // this limit, so it leaves a wide margin.
  localparam int HANG_LIMIT = 4000;

  // Settling time after the last expected result: the pipeline is seven stages
  // deep, so this is enough to catch any stray extra result.
  localparam int TAIL_CYCLES = 16;

  // One expected result word, field for field as it appears on out_ch.
  typedef struct packed {
    logic       negative;
    logic [3:0] digit_5;
    logic [3:0] digit_4;
    logic [3:0] digit_3;
    logic [3:0] digit_2;
    logic [3:0] digit_1;
    logic [3:0] digit_0;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic       range_error;
  } bcd_word_t;

  logic clk;
  logic rst_n;

  sbtp_in_if  in_ch ();
  sbtp_out_if out_ch ();

  signed_bcd_telemetry_pack_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Results still owed by the block, oldest first.
  bcd_word_t pending_words[$];
  int        errors;
  int        burst_left;
  // When set, neither the sender nor the receiver inserts any idle cycle.
  bit        steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expected result for one reading. The magnitude is taken in plain integer
  // arithmetic, clipped at the six-digit limit, and each digit and packed byte
  // is cut out of it by division, independent of how the block builds them.
  function automatic bcd_word_t pack_reading(kind_t kind, reading_t reading);
    bcd_word_t w;
    int        mag;
    int        pair;
    int        upper;
    int        lower;
    w = '0;
    mag = int'(reading);
    w.negative = (mag < 0);
    if (mag < 0) begin
      mag = -mag;
    end
    if (mag > int'(sbtp_pkg::MAG_LIMIT)) begin
      mag = int'(sbtp_pkg::MAG_LIMIT);
      w.range_error = 1'b1;
    end
    w.digit_5 = 4'(mag / 100000);
    w.digit_4 = 4'((mag / 10000) % 10);
    w.digit_3 = 4'((mag / 1000) % 10);
    w.digit_2 = 4'((mag / 100) % 10);
    w.digit_1 = 4'((mag / 10) % 10);
    w.digit_0 = 4'(mag % 10);
    case (kind)
      sbtp_pkg::KIND_TEMP: begin
        // Thousands and hundreds form the first byte, negated as an 8-bit
        // two's complement value for a negative reading.
        pair = (mag / 100) % 100;
        w.byte_0 = w.negative ? 8'(256 - pair) : 8'(pair);
        w.byte_1 = 8'(mag % 100);
      end
      sbtp_pkg::KIND_PRES: begin
        // Upper and lower three digits as two 16-bit values, high byte first.
        upper = mag / 1000;
        lower = mag % 1000;
        w.byte_0 = 8'(upper >> 8);
        w.byte_1 = 8'(upper & 'h00FF);
        w.byte_2 = 8'(lower >> 8);
        w.byte_3 = 8'(lower & 'h00FF);
      end
      sbtp_pkg::KIND_HUMI: begin
        // Hundred-thousands and units digits are dropped; two pairs from ten-thousands down to tens.
        w.byte_0 = 8'((mag / 1000) % 100);
        w.byte_1 = 8'((mag / 10) % 100);
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Readings are spread over the whole 21-bit range, the small values, the
  // band around the saturation point and the normal six-digit range.
  function automatic reading_t pick_reading();
    int mag;
    case ($urandom_range(0, 4))
      0: return reading_t'($urandom);
      1: mag = $urandom_range(0, 999);
      2: mag = $urandom_range(999990, 1000010);
      default: mag = $urandom_range(0, 999999);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      mag = -mag;
    end
    return reading_t'(mag);
  endfunction

  // The unused kind shows up about one word in ten.
  function automatic kind_t pick_kind();
    case ($urandom_range(0, 9))
      0, 1, 2: return sbtp_pkg::KIND_TEMP;
      3, 4, 5: return sbtp_pkg::KIND_PRES;
      6, 7, 8: return sbtp_pkg::KIND_HUMI;
      default: return KIND_UNUSED;
    endcase
  endfunction

  // Offers one word on in_ch and returns at the edge that accepts it. The
  // sender works in bursts; at the start of each burst it may drop valid for
  // a random gap. Valid is never lowered at the step where it is raised again.
  task automatic send_word(kind_t kind, reading_t reading);
    int gap;
    int pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (steady || pick < 3) begin
        gap = 0;
      end else if (pick < 9) begin
        gap = $urandom_range(1, 4);
      end else begin
        gap = $urandom_range(5, 12);
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.reading <= reading;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_words.push_back(pack_reading(kind, reading));
  endtask

  // Drops valid and holds off until every owed result has come back.
  // At least one edge passes so valid is not raised in the same step.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    burst_left = 0;
  endtask

  // Corner readings under every kind code: zero, minus one (a negative value
  // whose temperature pair is zero), the largest magnitude that fits, the
  // first one that saturates, and both ends of the 21-bit range, including
  // the most negative reading whose magnitude does not fit in 20 bits.
  task automatic test_directed();
    int    corner [6];
    kind_t all_kinds [4];
    corner    = '{0, -1, 999999, -1000000, 1048575, -1048576};
    all_kinds = '{sbtp_pkg::KIND_TEMP, sbtp_pkg::KIND_PRES, sbtp_pkg::KIND_HUMI, KIND_UNUSED};
    for (int r = 0; r < 6; r++) begin
      for (int k = 0; k < 4; k++) begin
        send_word(all_kinds[k], reading_t'(corner[r]));
      end
    end
    // A negative temperature with a nonzero pair exercises the byte negation.
    send_word(sbtp_pkg::KIND_TEMP, reading_t'(-123456));
  endtask

  // Bulk random words with both sides idling at random.
  task automatic test_random_mixed(int count);
    for (int i = 0; i < count; i++) begin
      send_word(pick_kind(), pick_reading());
    end
  endtask

  // Full-rate stretch: one word per cycle in and out with no stalls, so every
  // pipeline stage is occupied at once.
  task automatic test_back_to_back(int count);
    steady     = 1'b1;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      send_word(pick_kind(), pick_reading());
    end
    steady = 1'b0;
  endtask

  // Groups of words separated by a full drain, so the pipeline empties and
  // refills from idle several times.
  task automatic test_drain_pauses(int groups, int per_group);
    for (int g = 0; g < groups; g++) begin
      for (int i = 0; i < per_group; i++) begin
        send_word(pick_kind(), pick_reading());
      end
      wait_drained();
    end
  endtask

  // Receiver: out_ch.ready follows a 32-bit stall pattern, reloaded each time
  // it is used up with one of several densities, from no stall at all to
  // mostly stalled.
  initial begin
    logic [31:0] stall_pattern;
    int          stall_pos;
    out_ch.ready <= 1'b0;
    stall_pattern = '1;
    stall_pos     = 0;
    forever begin
      @(posedge clk);
      if (stall_pos == 32) begin
        stall_pos = 0;
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = $urandom | $urandom;
          2: stall_pattern = $urandom;
          default: stall_pattern = $urandom & $urandom;
        endcase
      end
      out_ch.ready <= steady ? 1'b1 : stall_pattern[stall_pos];
      stall_pos++;
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Every result word accepted on out_ch is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    bcd_word_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, %s %0d%0d%0d%0d%0d%0d",
                 $time, "got digits", out_ch.digit_5, out_ch.digit_4, out_ch.digit_3,
                 out_ch.digit_2, out_ch.digit_1, out_ch.digit_0);
      end else begin
        want = pending_words.pop_front();
        check_field("negative",    8'(want.negative),    8'(out_ch.negative));
        check_field("digit_5",     8'(want.digit_5),     8'(out_ch.digit_5));
        check_field("digit_4",     8'(want.digit_4),     8'(out_ch.digit_4));
        check_field("digit_3",     8'(want.digit_3),     8'(out_ch.digit_3));
        check_field("digit_2",     8'(want.digit_2),     8'(out_ch.digit_2));
        check_field("digit_1",     8'(want.digit_1),     8'(out_ch.digit_1));
        check_field("digit_0",     8'(want.digit_0),     8'(out_ch.digit_0));
        check_field("byte_0",      want.byte_0,          out_ch.byte_0);
        check_field("byte_1",      want.byte_1,          out_ch.byte_1);
        check_field("byte_2",      want.byte_2,          out_ch.byte_2);
        check_field("byte_3",      want.byte_3,          out_ch.byte_3);
        check_field("range_error", 8'(want.range_error), 8'(out_ch.range_error));
      end
    end
  end

  // Watchdog: any word moving on either channel restarts the count.
  always @(posedge clk) begin
    int quiet_cycles;
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
        $display("tb_signed_bcd_telemetry_pack_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    errors     = 0;
    burst_left = 0;
    steady     = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= sbtp_pkg::KIND_TEMP;
    in_ch.reading <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mixed(1200);
    test_back_to_back(200);
    test_drain_pauses(6, 40);
    test_random_mixed(10);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("tb_signed_bcd_telemetry_pack_top: done, clean");
    end else begin
      $display("tb_signed_bcd_telemetry_pack_top: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/sbtp_pkg.sv
sv/sbtp_if.sv
sv/sbtp_front.sv
sv/sbtp_dabble_cell.sv
sv/sbtp_pack.sv
sv/signed_bcd_telemetry_pack_top.sv
test/tb_signed_bcd_telemetry_pack_top.sv
